@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is quiet while reset is high.
`define MAF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define MAF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ hdl/maf_pkg.sv @@
`default_nettype none

package maf_pkg;

   // Widths fixed by the sample format and the configuration register.
   localparam int SAMPLE_W = 16;
   localparam int CSR_W    = 7;

   // Sequencer states of the filter.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_UPDATE,
      ST_MUL,
      ST_LAUNCH,
      ST_DIV,
      ST_HOLD
   } maf_state_type;

   // Status of the bit-serial divider.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

`default_nettype wire

@@ hdl/maf_ram.sv @@
`default_nettype none

module maf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/maf_serial_div.sv @@
`default_nettype none

module maf_serial_div #(
   parameter int DIVIDEND_W = 22,
   parameter int DIVISOR_W  = 7
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic signed [DIVIDEND_W-1:0]        dividend,
   input  wire logic        [DIVISOR_W-1:0]         divisor,
   output maf_pkg::div_stat_type                    stat,
   output logic signed      [maf_pkg::SAMPLE_W-1:0] quotient
);

   import maf_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic                  neg_ff, neg_in;

   logic [DIVIDEND_W-1:0] dvd_u;
   logic [DIVIDEND_W-1:0] mag;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;
   logic [SAMPLE_W-1:0]   q_low;

   // Magnitude of the dividend; the sign is applied to the quotient at the end.
   always_comb begin
      dvd_u = dividend;
      mag   = dvd_u[DIVIDEND_W-1] ? (~dvd_u + 1'b1) : dvd_u;
   end

   // One restoring step: bring down the next dividend bit and try to subtract.
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      neg_in  = neg_ff;
      priority if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = mag;
         neg_in  = dividend[DIVIDEND_W-1];
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   // The mean of 16-bit samples always fits 16 bits; negate for a negative total.
   assign q_low     = quo_ff[SAMPLE_W-1:0];
   assign quotient  = neg_ff ? (~q_low + 1'b1) : q_low;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

`default_nettype wire

@@ hdl/moving_average_filter_unit.sv @@
// Each accepted item reads the window store, updates the running total and is divided
// by the length; the first item after reset or a length write first forms a preload product.
// No new item is taken until the result is loaded into the output register, which waits
// while the result side stalls; the bit-serial divider produces one quotient bit per cycle.
// Reset is synchronous and active high; it sets the length to DEFAULT_LEN (clamped to
// 1..MAX_LENGTH) and the next item preloads the window. The sample store needs no clearing pass.
`default_nettype none

module moving_average_filter_unit #(
   parameter int MAX_LENGTH  = 64,
   parameter int DEFAULT_LEN = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [maf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed      [maf_pkg::SAMPLE_W-1:0] rsp_average,
   input  wire logic                                csr_wr_en,
   input  wire logic        [maf_pkg::CSR_W-1:0]    csr_wr_data
);

   import maf_pkg::*;

   localparam int POS_W     = $clog2(MAX_LENGTH);
   localparam int LEN_W     = $clog2(MAX_LENGTH + 1);
   localparam int TOTAL_W   = SAMPLE_W + $clog2(MAX_LENGTH);
   localparam int MUL_CNT_W = $clog2(LEN_W + 1);
   localparam int CMP_W     = (LEN_W > CSR_W) ? LEN_W : CSR_W;
   localparam int DEF_CLAMP = (DEFAULT_LEN < 1) ? 1 :
                              ((DEFAULT_LEN > MAX_LENGTH) ? MAX_LENGTH : DEFAULT_LEN);

   maf_state_type state_ff, state_in;

   logic [LEN_W-1:0]          len_ff, len_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic                      full_ff, full_in;
   logic                      first_ff, first_in;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] first_x_ff, first_x_in;
   logic signed [TOTAL_W-1:0] total_ff, total_in;
   logic [LEN_W-1:0]          mul_sr_ff, mul_sr_in;
   logic [MUL_CNT_W-1:0]      mul_cnt_ff, mul_cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_average_ff, rsp_average_in;

   logic                      accept;
   logic                      out_free;
   logic                      ram_rd_en;
   logic                      ram_wr_en;
   logic                      div_start;
   logic                      out_load;
   logic                      mul_run;
   logic [SAMPLE_W-1:0]       ram_rd_data;
   logic signed [SAMPLE_W-1:0] old_sample;
   logic signed [TOTAL_W-1:0] x_ext;
   logic signed [TOTAL_W-1:0] old_ext;
   logic [LEN_W-1:0]          pos_plus;
   logic                      pos_wrap;
   logic [CMP_W-1:0]          cfg_wide;
   logic [LEN_W-1:0]          cfg_len;
   div_stat_type              div_stat;
   logic signed [SAMPLE_W-1:0] div_quotient;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Window store: one entry written per item, read in the cycle before the update.
   maf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MAX_LENGTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (x_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (pos_ff),
      .rd_data (ram_rd_data)
   );

   // Bit-serial divider for the running total over the window length.
   maf_serial_div #(
      .DIVIDEND_W (TOTAL_W),
      .DIVISOR_W  (LEN_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (total_ff),
      .divisor  (len_ff),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // A zero length acts as one; a length above the store acts as the full store.
   always_comb begin
      cfg_wide = CMP_W'(csr_wr_data);
      priority if (cfg_wide == '0) begin
         cfg_len = LEN_W'(1);
      end else if (cfg_wide > CMP_W'(MAX_LENGTH)) begin
         cfg_len = LEN_W'(MAX_LENGTH);
      end else begin
         cfg_len = LEN_W'(cfg_wide);
      end
   end

   // Entries not yet overwritten since the restart still hold the preload sample.
   always_comb begin
      old_sample = full_ff ? $signed(ram_rd_data) : first_x_ff;
      x_ext      = TOTAL_W'(x_ff);
      old_ext    = TOTAL_W'(old_sample);
      pos_plus   = LEN_W'(pos_ff) + 1'b1;
      pos_wrap   = (pos_plus >= len_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in = first_ff ? ST_MUL : ST_LAUNCH;
         end
         ST_MUL: begin
            if (mul_cnt_ff == MUL_CNT_W'(1)) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_stat.done) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      ram_rd_en = (state_ff == ST_FETCH);
      ram_wr_en = (state_ff == ST_UPDATE);
      mul_run   = (state_ff == ST_MUL);
      div_start = (state_ff == ST_LAUNCH);
      out_load  = ((state_ff == ST_DIV) && div_stat.done && out_free) ||
                  ((state_ff == ST_HOLD) && out_free);
   end

   // Window bookkeeping, running total and the serial preload product.
   always_comb begin
      len_in     = len_ff;
      pos_in     = pos_ff;
      full_in    = full_ff;
      first_in   = first_ff;
      x_in       = x_ff;
      first_x_in = first_x_ff;
      total_in   = total_ff;
      mul_sr_in  = mul_sr_ff;
      mul_cnt_in = mul_cnt_ff;

      if (accept) begin
         x_in = req_sample;
      end

      if (ram_wr_en) begin
         pos_in  = pos_wrap ? '0 : POS_W'(pos_plus);
         full_in = full_ff || pos_wrap;
         if (first_ff) begin
            first_in   = 1'b0;
            first_x_in = x_ff;
            total_in   = '0;
            mul_sr_in  = len_ff;
            mul_cnt_in = MUL_CNT_W'(LEN_W);
         end else begin
            total_in = total_ff + x_ext - old_ext;
         end
      end

      // Preload total = sample times length, one length bit per cycle from the top.
      if (mul_run) begin
         total_in   = (total_ff <<< 1) + (mul_sr_ff[LEN_W-1] ? x_ext : '0);
         mul_sr_in  = mul_sr_ff << 1;
         mul_cnt_in = mul_cnt_ff - 1'b1;
      end

      // A length write restarts the filter with a fresh preload.
      if (csr_wr_en) begin
         len_in   = cfg_len;
         pos_in   = '0;
         full_in  = 1'b0;
         first_in = 1'b1;
         total_in = '0;
      end
   end

   // Output register, so a waiting item does not block the input side.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      priority if (out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_average_in = div_quotient;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= LEN_W'(DEF_CLAMP);
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         first_ff     <= 1'b1;
         total_ff     <= '0;
         mul_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         first_ff     <= first_in;
         total_ff     <= total_in;
         mul_cnt_ff   <= mul_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff           <= x_in;
      first_x_ff     <= first_x_in;
      mul_sr_ff      <= mul_sr_in;
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_average = rsp_average_ff;

endmodule

`default_nettype wire

@@ hdl/maf_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module maf_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic signed [maf_pkg::SAMPLE_W-1:0] rsp_average
);

   import maf_pkg::*;

   // A result item waits on the port until it is taken.
   `MAF_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result item dropped while stalled")
   `MAF_ASSERT(a_rsp_stable, rsp_valid && rsp_stall |=> $stable(rsp_average), "stalled result changed")

   // The filter works on one item at a time and does not produce its result at once.
   `MAF_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "item taken while busy")
   `MAF_ASSERT(a_no_early_result, req_valid && !req_stall |=> !$rose(rsp_valid), "result too early")

   // Reset empties the output register.
   `MAF_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind moving_average_filter_unit maf_checker u_maf_checker (.*);

`default_nettype wire
